// File: design/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

    localparam int RUN_BYTES_DEF = 512;

    localparam int NUM_BANKS = 2;
    localparam int BANK_W    = $clog2(NUM_BANKS);

    localparam int BYTE_W  = 8;
    localparam int LANES   = 8;
    localparam int LANE_W  = $clog2(LANES);
    localparam int CHUNK_W = LANES * BYTE_W;
    localparam int CNT_W   = 4;

    localparam int MIN_LEN_W = 9;
    localparam int OFS_W     = 32;

    localparam int OUT_FIELDS_W = CHUNK_W + CNT_W + OFS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd2;

    localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST = 9'd4;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic [MIN_LEN_W-1:0] min_length;
        logic [OFS_W-1:0]     window_start;
        logic [OFS_W-1:0]     window_end;
    } pse_cfg_t;

    function automatic logic is_printable(input logic [BYTE_W-1:0] c);
        return ((c >= CH_SPACE) && (c < CH_DEL)) || (c == CH_TAB);
    endfunction

endpackage

// File: design/pse_ram.sv
`timescale 1ns / 1ps

module pse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/pse_front.sv
`timescale 1ns / 1ps

module pse_front #(
    parameter int RUN_BYTES = pse_pkg::RUN_BYTES_DEF,
    localparam int LEN_W    = $clog2(RUN_BYTES),
    localparam int ROW_W    = LEN_W - pse_pkg::LANE_W,
    localparam int ADDR_W   = pse_pkg::BANK_W + ROW_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pse_pkg::pse_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pse_pkg::BYTE_W-1:0]  in_data,
    input  logic                        in_file_start,
    input  logic                        room,
    output logic                        ram_we,
    output logic [pse_pkg::LANE_W-1:0]  ram_lane,
    output logic [ADDR_W-1:0]           ram_addr,
    output logic [pse_pkg::BYTE_W-1:0]  ram_data,
    output logic                        cmd_push,
    output logic [pse_pkg::BANK_W-1:0]  cmd_bank,
    output logic [LEN_W-1:0]            cmd_len,
    output logic [pse_pkg::OFS_W-1:0]   cmd_start
);

    import pse_pkg::*;

    localparam int CMP_W = (LEN_W > MIN_LEN_W) ? LEN_W : MIN_LEN_W;

    logic [OFS_W-1:0]  pos_reg, pos_next, pos;
    logic [LEN_W-1:0]  len_reg, len_next, len;
    logic [BANK_W-1:0] bank_reg, bank_next;
    logic              outside, term, long_run, enough, accept;

    assign in_ready = room;

    always_comb
    begin
        pos      = in_file_start ? '0 : pos_reg;
        len      = in_file_start ? '0 : len_reg;
        outside  = (pos < cfg.window_start) ||
                   ((cfg.window_end != '0) && (pos >= cfg.window_end));
        term     = (in_data == CH_NUL) || (in_data == CH_LF);
        long_run = len >= LEN_W'(RUN_BYTES - 1);
        enough   = CMP_W'(len) >= CMP_W'(cfg.min_length);
        accept   = in_valid && room;

        pos_next  = pos_reg;
        len_next  = len_reg;
        bank_next = bank_reg;
        ram_we    = 1'b0;
        cmd_push  = 1'b0;

        if (accept)
        begin
            pos_next = pos + 1'b1;
            if (outside)
            begin
                len_next = '0;
            end
            else if ((term && enough) || long_run)
            begin
                cmd_push  = 1'b1;
                len_next  = '0;
                bank_next = bank_reg + BANK_W'(1);
            end
            else if (is_printable(in_data))
            begin
                ram_we   = 1'b1;
                len_next = len + 1'b1;
            end
            else
            begin
                len_next = '0;
            end
        end

        ram_lane  = len[LANE_W-1:0];
        ram_addr  = {bank_reg, len[LEN_W-1:LANE_W]};
        ram_data  = in_data;
        cmd_bank  = bank_reg;
        cmd_len   = len;
        cmd_start = pos - OFS_W'(len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            bank_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// File: design/pse_cmd_fifo.sv
`timescale 1ns / 1ps

module pse_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] head
);

    import pse_pkg::*;

    logic [WIDTH-1:0]  slots [NUM_BANKS];
    logic [BANK_W-1:0] wptr_reg, rptr_reg;
    logic [BANK_W:0]   count_reg;

    assign empty = (count_reg == '0);
    assign head  = slots[rptr_reg];

    // depth matches the bank count; the front never pushes when full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + BANK_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + BANK_W'(1);
            end
            count_reg <= count_reg + (BANK_W+1)'(push) - (BANK_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wptr_reg] <= push_data;
        end
    end

endmodule

// File: design/pse_back.sv
`timescale 1ns / 1ps

module pse_back #(
    parameter int RUN_BYTES = pse_pkg::RUN_BYTES_DEF,
    localparam int LEN_W    = $clog2(RUN_BYTES),
    localparam int ROW_W    = LEN_W - pse_pkg::LANE_W,
    localparam int ADDR_W   = pse_pkg::BANK_W + ROW_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_pop,
    input  logic [pse_pkg::BANK_W-1:0]   cmd_bank,
    input  logic [LEN_W-1:0]             cmd_len,
    input  logic [pse_pkg::OFS_W-1:0]    cmd_start,
    output logic                         rd_en,
    output logic [ADDR_W-1:0]            rd_addr,
    input  logic [pse_pkg::CHUNK_W-1:0]  rd_data,
    output logic                         done,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pse_pkg::CHUNK_W-1:0]  out_chunk,
    output logic [pse_pkg::CNT_W-1:0]    out_bytes,
    output logic [pse_pkg::OFS_W-1:0]    out_offset,
    output logic                         out_last
);

    import pse_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOAD
    } state_t;

    state_t              state_reg;
    logic [BANK_W-1:0]   bank_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [OFS_W-1:0]    start_reg;
    logic                out_valid_reg;
    logic [CHUNK_W-1:0]  chunk_reg;
    logic [CNT_W-1:0]    bytes_reg;
    logic [OFS_W-1:0]    offset_reg;
    logic                last_reg;

    logic                last;
    logic [CNT_W-1:0]    n;
    logic [CHUNK_W-1:0]  masked;
    logic                load_ok;

    assign out_valid  = out_valid_reg;
    assign out_chunk  = chunk_reg;
    assign out_bytes  = bytes_reg;
    assign out_offset = offset_reg;
    assign out_last   = last_reg;

    always_comb
    begin
        last    = rem_reg <= LEN_W'(LANES);
        n       = last ? rem_reg[CNT_W-1:0] : CNT_W'(LANES);
        load_ok = !out_valid_reg || out_ready;
        for (int i = 0; i < LANES; i++)
        begin
            masked[i*BYTE_W +: BYTE_W] = (CNT_W'(i) < n) ? rd_data[i*BYTE_W +: BYTE_W] : '0;
        end

        cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
        done    = (state_reg == ST_LOAD) && load_ok && last;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_en   = cmd_valid;
                rd_addr = {cmd_bank, {ROW_W{1'b0}}};
            end
            ST_LOAD:
            begin
                rd_en   = load_ok && !last;
                rd_addr = {bank_reg, row_reg + ROW_W'(1)};
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= '0;
            row_reg       <= '0;
            rem_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
            chunk_reg     <= '0;
            bytes_reg     <= '0;
            offset_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (cmd_valid)
                    begin
                        bank_reg  <= cmd_bank;
                        rem_reg   <= cmd_len;
                        start_reg <= cmd_start;
                        row_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    // load_ok low means the chunk is held, so valid stays up
                    if (load_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        chunk_reg     <= masked;
                        bytes_reg     <= n;
                        offset_reg    <= start_reg;
                        last_reg      <= last;
                        if (last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            rem_reg <= rem_reg - LEN_W'(LANES);
                            row_reg <= row_reg + ROW_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/printable_string_extractor.sv
`timescale 1ns / 1ps
// Printable string extractor.
// s_axis carries file bytes, one per request; tuser marks the byte at file
// offset zero. m_axis carries each found string as 8-byte chunks with the
// string's start offset; tlast marks the final chunk of a string.
// cfg_wr_en/cfg_index/cfg_data write min_length, window_start and
// window_end; write only while the block is idle.
// Throughput: one input byte per cycle while scanning. A string drains at
// one chunk per cycle while m_axis is ready, from eight byte-lane RAMs (one
// row per chunk), after the back part's idle state starts it. The run
// buffer has two banks, so input stalls while two strings are queued or
// draining, until the back part finishes one and frees its bank.
// After the terminating byte is accepted, its string passes through the
// command FIFO and the RAM read before the first chunk is registered.
// Reset clears the run, the file position and the configuration
// (min_length 4, whole file scanned). When m_axis stalls, the chunk
// holds in the output register and the queue backs up into s_axis.

module printable_string_extractor #(
    parameter int RUN_BYTES = pse_pkg::RUN_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // data_byte
    input  logic                            s_axis_tuser,   // file_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // chunk[63:0], chunk_bytes[67:64], string_offset[99:68], zero pad
    output logic [pse_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast    // last_chunk
);

    import pse_pkg::*;

    localparam int LEN_W     = $clog2(RUN_BYTES);
    localparam int ROW_W     = LEN_W - LANE_W;
    localparam int ADDR_W    = BANK_W + ROW_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int CMD_W     = BANK_W + LEN_W + OFS_W;

    pse_cfg_t            cfg_reg;
    logic [BANK_W:0]     pending_reg;
    logic                room;

    logic                ram_we;
    logic [LANE_W-1:0]   ram_lane;
    logic [ADDR_W-1:0]   ram_addr;
    logic [BYTE_W-1:0]   ram_data;

    logic                cmd_push, cmd_pop, cmd_empty;
    logic [BANK_W-1:0]   cmd_bank, head_bank;
    logic [LEN_W-1:0]    cmd_len, head_len;
    logic [OFS_W-1:0]    cmd_start, head_start;
    logic [CMD_W-1:0]    head;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CHUNK_W-1:0]  rd_data;
    logic                back_done;

    logic [CHUNK_W-1:0]  out_chunk;
    logic [CNT_W-1:0]    out_bytes;
    logic [OFS_W-1:0]    out_offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length   <= MIN_LENGTH_RST;
            cfg_reg.window_start <= '0;
            cfg_reg.window_end   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN_LENGTH:   cfg_reg.min_length   <= cfg_data[MIN_LEN_W-1:0];
                REG_WINDOW_START: cfg_reg.window_start <= cfg_data[OFS_W-1:0];
                REG_WINDOW_END:   cfg_reg.window_end   <= cfg_data[OFS_W-1:0];
                default:          ;
            endcase
        end
    end

    // strings queued or draining; each one holds a buffer bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + (BANK_W+1)'(cmd_push) - (BANK_W+1)'(back_done);
        end
    end

    assign room = pending_reg < (BANK_W+1)'(NUM_BANKS);

    pse_front #(
        .RUN_BYTES (RUN_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (s_axis_tdata),
        .in_file_start (s_axis_tuser),
        .room          (room),
        .ram_we        (ram_we),
        .ram_lane      (ram_lane),
        .ram_addr      (ram_addr),
        .ram_data      (ram_data),
        .cmd_push      (cmd_push),
        .cmd_bank      (cmd_bank),
        .cmd_len       (cmd_len),
        .cmd_start     (cmd_start)
    );

    pse_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data ({cmd_bank, cmd_len, cmd_start}),
        .pop       (cmd_pop),
        .empty     (cmd_empty),
        .head      (head)
    );

    assign {head_bank, head_len, head_start} = head;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        pse_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (RAM_DEPTH)
        ) u_lane (
            .clk   (clk),
            .we    (ram_we && (ram_lane == LANE_W'(g))),
            .waddr (ram_addr),
            .wdata (ram_data),
            .re    (rd_en),
            .raddr (rd_addr),
            .rdata (rd_data[g*BYTE_W +: BYTE_W])
        );
    end

    pse_back #(
        .RUN_BYTES (RUN_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!cmd_empty),
        .cmd_pop    (cmd_pop),
        .cmd_bank   (head_bank),
        .cmd_len    (head_len),
        .cmd_start  (head_start),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .done       (back_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_chunk  (out_chunk),
        .out_bytes  (out_bytes),
        .out_offset (out_offset),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_offset, out_bytes, out_chunk};

endmodule
